>>> sv/tdr_pkg.sv
// shared types, register indexes and constants for the temporal detection rule core
package tdr_pkg;

  localparam int unsigned MASK_W    = 16;
  localparam int unsigned ZONE_W    = 4;
  localparam int unsigned MINUTE_W  = 11;
  localparam int unsigned TIME_W    = 40;
  localparam int unsigned SUBJECT_W = 2;
  localparam int unsigned SECS_W    = 24;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_KIND  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_CLASS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTOR_CLASS   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_SELECT   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL         = 4'd7;

  // trigger kinds
  localparam logic [1:0] TRIG_APPEARS     = 2'd0;
  localparam logic [1:0] TRIG_SUSTAINED   = 2'd1;
  localparam logic [1:0] TRIG_LEFT_BEHIND = 2'd2;
  localparam logic [1:0] TRIG_UNUSED      = 2'd3;

  // subject codes
  localparam logic [SUBJECT_W-1:0] SUBJ_PERSON  = 2'd0;
  localparam logic [3:0]           CLASS_VEHICLE = 4'd1;
  localparam logic [3:0]           CLASS_PACKAGE = 4'd3;

  localparam logic [4:0]          ZONE_ANY        = 5'd16;
  localparam logic [MINUTE_W-1:0] WINDOW_END_RST  = 11'd1440;

  typedef struct packed {
    logic [1:0]          trigger_kind;
    logic [3:0]          object_class;
    logic [3:0]          actor_class;
    logic [4:0]          zone_select;
    logic [MINUTE_W-1:0] window_start_min;
    logic [MINUTE_W-1:0] window_end_min;
    logic [SECS_W-1:0]   cooldown_seconds;
    logic [SECS_W-1:0]   dwell_seconds;
  } cfg_t;

  typedef struct packed {
    logic              object_was_present;
    logic              presence_run_valid;
    logic [TIME_W-1:0] presence_run_start;
    logic              object_ever_seen;
    logic              actor_was_present;
    logic              has_alerted;
    logic [TIME_W-1:0] last_alert_seconds;
  } rule_state_t;

endpackage

>>> sv/tdr_eval.sv
// rule evaluation for one observation: trigger, zone, window and cooldown gates
module tdr_eval (
  input  tdr_pkg::cfg_t                   cfg,
  input  tdr_pkg::rule_state_t            st,
  input  logic [tdr_pkg::MASK_W-1:0]      presence_mask,
  input  logic [tdr_pkg::ZONE_W-1:0]      zone,
  input  logic [tdr_pkg::MINUTE_W-1:0]    day_minute,
  input  logic [tdr_pkg::TIME_W-1:0]      time_seconds,
  output tdr_pkg::rule_state_t            st_nxt,
  output logic                            emit,
  output logic [tdr_pkg::SUBJECT_W-1:0]   subject
);
  import tdr_pkg::*;

  logic              present;
  logic              actor;
  logic              fired;
  logic [TIME_W-1:0] run_start;
  logic [TIME_W-1:0] run_len;
  logic [TIME_W-1:0] since_alert;
  logic              zone_ok;
  logic              window_ok;
  logic              cool_ok;

  assign present     = presence_mask[cfg.object_class];
  assign actor       = presence_mask[cfg.actor_class];
  assign run_start   = st.presence_run_valid ? st.presence_run_start : time_seconds;
  assign run_len     = time_seconds - run_start;
  assign since_alert = time_seconds - st.last_alert_seconds;

  always_comb begin
    st_nxt = st;
    fired  = 1'b0;
    unique case (cfg.trigger_kind)
      TRIG_APPEARS: begin
        fired = present && !st.object_was_present;
      end
      TRIG_SUSTAINED: begin
        if (present) begin
          st_nxt.presence_run_valid = 1'b1;
          st_nxt.presence_run_start = run_start;
          fired = (time_seconds >= run_start) &&
                  (run_len >= {{(TIME_W-SECS_W){1'b0}}, cfg.dwell_seconds});
        end else begin
          st_nxt.presence_run_valid = 1'b0;
        end
      end
      TRIG_LEFT_BEHIND: begin
        st_nxt.object_ever_seen  = st.object_ever_seen || present;
        fired = (st.object_ever_seen || present) && present &&
                st.actor_was_present && !actor;
        st_nxt.actor_was_present = actor;
      end
      TRIG_UNUSED: begin
        fired = 1'b0;
      end
      default: begin
        fired = 1'b0;
      end
    endcase
    st_nxt.object_was_present = present;

    zone_ok = (cfg.zone_select == ZONE_ANY) || (cfg.zone_select == {1'b0, zone});
    if (cfg.window_start_min <= cfg.window_end_min) begin
      window_ok = (day_minute >= cfg.window_start_min) &&
                  (day_minute < cfg.window_end_min);
    end else begin
      window_ok = (day_minute >= cfg.window_start_min) ||
                  (day_minute < cfg.window_end_min);
    end
    cool_ok = !st.has_alerted ||
              ((time_seconds >= st.last_alert_seconds) &&
               (since_alert >= {{(TIME_W-SECS_W){1'b0}}, cfg.cooldown_seconds}));

    emit = fired && zone_ok && window_ok && cool_ok;
    if (emit) begin
      st_nxt.has_alerted        = 1'b1;
      st_nxt.last_alert_seconds = time_seconds;
    end
  end

  assign subject = ((cfg.object_class >= CLASS_VEHICLE) &&
                    (cfg.object_class <= CLASS_PACKAGE)) ?
                   cfg.object_class[SUBJECT_W-1:0] : SUBJ_PERSON;

endmodule

>>> sv/temporal_detection_rule_core.sv
// Temporal detection rule core: one rule over a stream of observations. A request
// is captured in an input register, evaluated against the rule state and any alert
// lands in an output register, so one request is taken every clock cycle while the
// output register holds no untaken alert. The output register stalls the input side
// only when it holds an alert that has not been taken. Any configuration write with
// a valid index clears the rule state; configuration is to be written by the user only
// while the core is idle, and the core itself does not enforce this.
module temporal_detection_rule_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tdr_pkg::MASK_W-1:0]        in_presence_mask,
  input  logic [tdr_pkg::ZONE_W-1:0]        in_zone,
  input  logic [tdr_pkg::MINUTE_W-1:0]      in_day_minute,
  input  logic [tdr_pkg::TIME_W-1:0]        in_time_seconds,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tdr_pkg::SUBJECT_W-1:0]     out_subject,
  output logic [tdr_pkg::TIME_W-1:0]        out_alert_seconds,
  input  logic                              cfg_wr_en,
  input  logic [tdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdr_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import tdr_pkg::*;

  cfg_t                 cfg_r;
  rule_state_t          st_r;
  rule_state_t          st_nxt;
  logic                 s1_valid_r;
  logic [MASK_W-1:0]    s1_mask_r;
  logic [ZONE_W-1:0]    s1_zone_r;
  logic [MINUTE_W-1:0]  s1_minute_r;
  logic [TIME_W-1:0]    s1_time_r;
  logic                 out_valid_r;
  logic [SUBJECT_W-1:0] out_subject_r;
  logic [TIME_W-1:0]    out_time_r;
  logic                 emit;
  logic [SUBJECT_W-1:0] subject;
  logic                 advance;
  logic                 cfg_hit;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_hit   = cfg_wr_en && (cfg_index <= REG_DWELL);

  tdr_eval u_eval (
    .cfg           (cfg_r),
    .st            (st_r),
    .presence_mask (s1_mask_r),
    .zone          (s1_zone_r),
    .day_minute    (s1_minute_r),
    .time_seconds  (s1_time_r),
    .st_nxt        (st_nxt),
    .emit          (emit),
    .subject       (subject)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_kind     <= TRIG_APPEARS;
      cfg_r.object_class     <= '0;
      cfg_r.actor_class      <= '0;
      cfg_r.zone_select      <= ZONE_ANY;
      cfg_r.window_start_min <= '0;
      cfg_r.window_end_min   <= WINDOW_END_RST;
      cfg_r.cooldown_seconds <= '0;
      cfg_r.dwell_seconds    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TRIGGER_KIND: cfg_r.trigger_kind     <= cfg_wdata[1:0];
        REG_OBJECT_CLASS: cfg_r.object_class     <= cfg_wdata[3:0];
        REG_ACTOR_CLASS:  cfg_r.actor_class      <= cfg_wdata[3:0];
        REG_ZONE_SELECT:  cfg_r.zone_select      <= cfg_wdata[4:0];
        REG_WINDOW_START: cfg_r.window_start_min <= cfg_wdata[MINUTE_W-1:0];
        REG_WINDOW_END:   cfg_r.window_end_min   <= cfg_wdata[MINUTE_W-1:0];
        REG_COOLDOWN:     cfg_r.cooldown_seconds <= cfg_wdata[SECS_W-1:0];
        REG_DWELL:        cfg_r.dwell_seconds    <= cfg_wdata[SECS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // rule state
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mask_r   <= in_presence_mask;
      s1_zone_r   <= in_zone;
      s1_minute_r <= in_day_minute;
      s1_time_r   <= in_time_seconds;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_subject_r <= subject;
      out_time_r    <= s1_time_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_subject       = out_subject_r;
  assign out_alert_seconds = out_time_r;

endmodule

>>> bench/tb.sv
// self-checking bench for the temporal detection rule core: directed and random observations
module tb;
  import tdr_pkg::*;

  typedef struct {
    logic [MASK_W-1:0]   mask;
    logic [ZONE_W-1:0]   zone;
    logic [MINUTE_W-1:0] minute;
    logic [TIME_W-1:0]   secs;
    bit                  drain;
  } observation_t;

  typedef struct {
    logic [SUBJECT_W-1:0] subject;
    logic [TIME_W-1:0]    secs;
  } alert_t;

  localparam logic [TIME_W-1:0]    TIME_MAX     = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;
  localparam int                   CYCLE_LIMIT  = 400000;
  localparam int                   RANDOM_ITEMS = 1100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MASK_W-1:0]    in_presence_mask = '0;
  logic [ZONE_W-1:0]    in_zone = '0;
  logic [MINUTE_W-1:0]  in_day_minute = '0;
  logic [TIME_W-1:0]    in_time_seconds = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SUBJECT_W-1:0] out_subject;
  logic [TIME_W-1:0]    out_alert_seconds;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  temporal_detection_rule_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_presence_mask  (in_presence_mask),
    .in_zone           (in_zone),
    .in_day_minute     (in_day_minute),
    .in_time_seconds   (in_time_seconds),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_subject       (out_subject),
    .out_alert_seconds (out_alert_seconds),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  cfg_t              rule;
  rule_state_t       rule_st;
  observation_t      obs_q[$];
  alert_t            alerts_q[$];
  observation_t      cur_obs;
  bit                req_busy = 1'b0;
  bit                req_taken = 1'b0;
  bit                alert_taken = 1'b0;
  int                gap_left = 0;
  int                stall_left = 0;
  bit                gaps_on = 1'b1;
  bit                stalls_on = 1'b1;
  int                errors = 0;
  int                cycles = 0;
  logic [TIME_W-1:0] clock_now = '0;
  bit                obj_here = 1'b0;
  bit                actor_here = 1'b0;
  bit                drained_once = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (errors < 100) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
    errors++;
  endtask

  task automatic evaluate_observation(input observation_t o);
    logic   seen, actor, fired, zone_ok, window_ok, cool_ok;
    alert_t hit;
    seen  = o.mask[rule.object_class];
    actor = o.mask[rule.actor_class];
    fired = 1'b0;
    case (rule.trigger_kind)
      TRIG_APPEARS: begin
        fired = seen && !rule_st.object_was_present;
      end
      TRIG_SUSTAINED: begin
        if (seen) begin
          if (!rule_st.presence_run_valid) begin
            rule_st.presence_run_valid = 1'b1;
            rule_st.presence_run_start = o.secs;
          end
          fired = (o.secs >= rule_st.presence_run_start) &&
                  ((o.secs - rule_st.presence_run_start) >= rule.dwell_seconds);
        end else begin
          rule_st.presence_run_valid = 1'b0;
        end
      end
      TRIG_LEFT_BEHIND: begin
        if (seen) begin
          rule_st.object_ever_seen = 1'b1;
        end
        fired = rule_st.object_ever_seen && seen && rule_st.actor_was_present && !actor;
        rule_st.actor_was_present = actor;
      end
      default: begin
      end
    endcase
    rule_st.object_was_present = seen;

    zone_ok = (rule.zone_select == ZONE_ANY) || (rule.zone_select == {1'b0, o.zone});
    if (rule.window_start_min <= rule.window_end_min) begin
      window_ok = (o.minute >= rule.window_start_min) && (o.minute < rule.window_end_min);
    end else begin
      window_ok = (o.minute >= rule.window_start_min) || (o.minute < rule.window_end_min);
    end
    cool_ok = !rule_st.has_alerted ||
              ((o.secs >= rule_st.last_alert_seconds) &&
               ((o.secs - rule_st.last_alert_seconds) >= rule.cooldown_seconds));

    if (fired && zone_ok && window_ok && cool_ok) begin
      rule_st.has_alerted        = 1'b1;
      rule_st.last_alert_seconds = o.secs;
      hit.subject = (rule.object_class >= CLASS_VEHICLE && rule.object_class <= CLASS_PACKAGE) ?
                    rule.object_class[SUBJECT_W-1:0] : SUBJ_PERSON;
      hit.secs    = o.secs;
      alerts_q = {alerts_q, hit};
    end
  endtask

  task automatic check_alert();
    alert_t want;
    if (alerts_q.size() == 0) begin
      report_mismatch($sformatf("unexpected alert subject %0d seconds %0d",
                                out_subject, out_alert_seconds));
      return;
    end
    want = alerts_q.pop_front();
    if (out_subject !== want.subject) begin
      report_mismatch($sformatf("subject got %0d want %0d", out_subject, want.subject));
    end
    if (out_alert_seconds !== want.secs) begin
      report_mismatch($sformatf("alert_seconds got %0d want %0d",
                                out_alert_seconds, want.secs));
    end
  endtask

  // request side
  always @(posedge clk) begin : request_accept
    if (rst_n && in_valid && in_ready) begin
      evaluate_observation(cur_obs);
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : request_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (req_taken) begin
        req_taken = 1'b0;
        req_busy  = 1'b0;
        gap_left  = gaps_on ? $urandom_range(0, 5) : 0;
      end
      if (!req_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (obs_q.size() != 0 && !(obs_q[0].drain && alerts_q.size() != 0)) begin
          cur_obs  = obs_q.pop_front();
          req_busy = 1'b1;
          in_presence_mask <= cur_obs.mask;
          in_zone          <= cur_obs.zone;
          in_day_minute    <= cur_obs.minute;
          in_time_seconds  <= cur_obs.secs;
        end
      end
      in_valid <= req_busy;
    end
  end

  // alert side
  always @(posedge clk) begin : alert_monitor
    if (rst_n && out_valid && out_ready) begin
      check_alert();
      alert_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : alert_ready_driver
    if (alert_taken) begin
      alert_taken = 1'b0;
      stall_left  = stalls_on ? $urandom_range(0, 5) : 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TRIGGER_KIND: rule.trigger_kind     = val[1:0];
      REG_OBJECT_CLASS: rule.object_class     = val[3:0];
      REG_ACTOR_CLASS:  rule.actor_class      = val[3:0];
      REG_ZONE_SELECT:  rule.zone_select      = val[4:0];
      REG_WINDOW_START: rule.window_start_min = val[MINUTE_W-1:0];
      REG_WINDOW_END:   rule.window_end_min   = val[MINUTE_W-1:0];
      REG_COOLDOWN:     rule.cooldown_seconds = val[SECS_W-1:0];
      REG_DWELL:        rule.dwell_seconds    = val[SECS_W-1:0];
      default:          return;
    endcase
    rule_st = '0;
  endtask

  task automatic finish_writes();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_rule(input logic [CFG_DAT_W-1:0] kind, obj, actor, zsel,
                            wstart, wend, cool, dwell);
    write_reg(REG_TRIGGER_KIND, kind);
    write_reg(REG_OBJECT_CLASS, obj);
    write_reg(REG_ACTOR_CLASS, actor);
    write_reg(REG_ZONE_SELECT, zsel);
    write_reg(REG_WINDOW_START, wstart);
    write_reg(REG_WINDOW_END, wend);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_DWELL, dwell);
    finish_writes();
  endtask

  // waits for the core to drain, then lets requests that raise nothing pass through
  task automatic settle();
    while (obs_q.size() != 0 || req_busy || alerts_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic add_obs(input logic [MASK_W-1:0] mask, input logic [ZONE_W-1:0] zone,
                         input logic [MINUTE_W-1:0] minute, input logic [TIME_W-1:0] secs);
    observation_t o;
    o.mask   = mask;
    o.zone   = zone;
    o.minute = minute;
    o.secs   = secs;
    o.drain  = 1'b0;
    obs_q = {obs_q, o};
  endtask

  function automatic logic [SECS_W-1:0] pick_seconds();
    int                roll;
    logic [SECS_W-1:0] v;
    roll = $urandom_range(0, 9);
    if (roll < 3) begin
      v = '0;
    end else if (roll < 9) begin
      v = $urandom_range(1, 30);
    end else begin
      v = ($urandom_range(0, 1) == 0) ? '1 : $urandom;
    end
    return v;
  endfunction

  task automatic pick_random_rule();
    logic [CFG_DAT_W-1:0] v [8];
    int                   r, roll;
    for (r = 0; r < 8; r++) begin
      v[r] = ($urandom_range(0, 3) == 0) ? $urandom : 0;
    end
    v[REG_TRIGGER_KIND][1:0] = ($urandom_range(0, 9) == 0) ? TRIG_UNUSED : $urandom_range(0, 2);
    v[REG_OBJECT_CLASS][3:0] = $urandom_range(0, 15);
    v[REG_ACTOR_CLASS][3:0]  = $urandom_range(0, 15);
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      v[REG_ZONE_SELECT][4:0] = ZONE_ANY;
    end else if (roll < 9) begin
      v[REG_ZONE_SELECT][4:0] = $urandom_range(0, 15);
    end else begin
      v[REG_ZONE_SELECT][4:0] = $urandom_range(17, 31);
    end
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      v[REG_WINDOW_START][MINUTE_W-1:0] = '0;
      v[REG_WINDOW_END][MINUTE_W-1:0]   = WINDOW_END_RST;
    end else if (roll < 8) begin
      v[REG_WINDOW_START][MINUTE_W-1:0] = $urandom_range(0, 1439);
      v[REG_WINDOW_END][MINUTE_W-1:0]   = $urandom_range(0, 1440);
    end else if (roll == 8) begin
      v[REG_WINDOW_START][MINUTE_W-1:0] = $urandom_range(0, 1439);
      v[REG_WINDOW_END][MINUTE_W-1:0]   = v[REG_WINDOW_START][MINUTE_W-1:0];
    end else begin
      v[REG_WINDOW_START][MINUTE_W-1:0] = $urandom_range(0, 2047);
      v[REG_WINDOW_END][MINUTE_W-1:0]   = $urandom_range(0, 2047);
    end
    v[REG_COOLDOWN] = pick_seconds();
    v[REG_DWELL]    = pick_seconds();
    write_rule(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);

    roll = $urandom_range(0, 3);
    if (roll == 0) begin
      clock_now = '0;
    end else if (roll == 1) begin
      clock_now = TIME_MAX - $urandom_range(0, 1 << 26);
    end else begin
      clock_now = {8'($urandom), 32'($urandom)};
    end
    obj_here   = 1'b0;
    actor_here = 1'b0;
  endtask

  // mostly structured presence runs, with some fully random masks as noise
  task automatic queue_random_phase(input int n);
    observation_t      o;
    int                k, roll, step_max;
    logic [TIME_W-1:0] span;
    step_max = $urandom_range(0, 12);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        obj_here = !obj_here;
      end
      if ($urandom_range(0, 2) == 0) begin
        actor_here = !actor_here;
      end
      o.mask = $urandom;
      if ($urandom_range(0, 9) != 0) begin
        o.mask[rule.object_class] = obj_here;
        o.mask[rule.actor_class]  = actor_here;
      end
      if (rule.zone_select < ZONE_ANY && $urandom_range(0, 3) != 0) begin
        o.zone = rule.zone_select[ZONE_W-1:0];
      end else begin
        o.zone = $urandom_range(0, 15);
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        o.minute = $urandom_range(1440, 2047);
      end else if (roll == 1) begin
        case ($urandom_range(0, 2))
          0:       o.minute = rule.window_start_min;
          1:       o.minute = rule.window_end_min;
          default: o.minute = rule.window_end_min - 1'b1;
        endcase
      end else begin
        o.minute = $urandom_range(0, 1439);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3 && clock_now >= 5) begin
        clock_now = clock_now - $urandom_range(1, 5);
      end else begin
        span = (roll < 7) ? $urandom_range(0, 1 << 25) : $urandom_range(0, step_max);
        clock_now = (TIME_MAX - clock_now < span) ? TIME_MAX : clock_now + span;
      end
      o.secs  = clock_now;
      o.drain = (!drained_once && k == n / 2) || ($urandom_range(0, 79) == 0);
      if (o.drain) begin
        drained_once = 1'b1;
      end
      obs_q = {obs_q, o};
    end
  endtask

  initial begin : stimulus
    int                total, n;
    logic [TIME_W-1:0] t_base;
    rule                = '0;
    rule.zone_select    = ZONE_ANY;
    rule.window_end_min = WINDOW_END_RST;
    rule_st             = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset rule: appears on class 0, any zone, whole day
    add_obs(16'h0000, 4'd0, 11'd0, 40'd0);
    add_obs(16'hFFFF, 4'd15, 11'd1439, 40'd0);
    add_obs(16'h0000, 4'd0, 11'd0, 40'd1);
    add_obs(16'h0001, 4'd7, 11'd2047, 40'd2);
    settle();

    // unmapped index leaves the rule and its state alone
    write_reg(REG_UNMAPPED, 24'hFFFFFF);
    finish_writes();
    add_obs(16'h0001, 4'd0, 11'd0, 40'd3);
    add_obs(16'h0000, 4'd0, 11'd0, 40'd4);
    add_obs(16'h0001, 4'd0, 11'd0, 40'd5);
    settle();

    // sustained package, wrapping window, cooldown and time going backwards
    write_rule(TRIG_SUSTAINED, CLASS_PACKAGE, 0, 5, 1439, 1, 10, 3);
    add_obs(16'h0008, 4'd5, 11'd1439, 40'd100);
    add_obs(16'h0008, 4'd5, 11'd0, 40'd103);
    add_obs(16'h0008, 4'd5, 11'd0, 40'd104);
    add_obs(16'h0008, 4'd5, 11'd0, 40'd99);
    add_obs(16'h0008, 4'd4, 11'd0, 40'd113);
    add_obs(16'h0008, 4'd5, 11'd1, 40'd113);
    add_obs(16'h0008, 4'd5, 11'd0, 40'd113);
    add_obs(16'h0008, 4'd5, 11'd0, 40'd110);
    settle();

    // left behind on the top class bits
    write_rule(TRIG_LEFT_BEHIND, 15, 14, ZONE_ANY, 0, WINDOW_END_RST, 0, 0);
    add_obs(16'h4000, 4'd1, 11'd10, 40'd0);
    add_obs(16'hC000, 4'd1, 11'd10, 40'd1);
    add_obs(16'h8000, 4'd1, 11'd10, 40'd2);
    add_obs(16'h8000, 4'd1, 11'd10, 40'd3);
    settle();

    // unused trigger kind never raises
    write_rule(TRIG_UNUSED, CLASS_VEHICLE, 0, ZONE_ANY, 0, WINDOW_END_RST, 0, 0);
    add_obs(16'h0000, 4'd3, 11'd100, TIME_MAX);
    add_obs(16'hFFFF, 4'd3, 11'd100, TIME_MAX);
    settle();

    // largest dwell and cooldown near the top of the time range
    t_base = TIME_MAX - (40'd1 << 25);
    write_rule(TRIG_SUSTAINED, 2, 0, ZONE_ANY, 0, 2047, 24'hFFFFFF, 24'hFFFFFF);
    add_obs(16'h0004, 4'd9, 11'd2000, t_base);
    add_obs(16'h0004, 4'd9, 11'd2000, t_base + 40'hFFFFFF);
    add_obs(16'h0004, 4'd9, 11'd2000, t_base + 40'hFFFFFF + 40'hFFFFFE);
    add_obs(16'h0004, 4'd9, 11'd2000, TIME_MAX);
    settle();

    // zone select above any
    write_rule(TRIG_APPEARS, CLASS_VEHICLE, 0, 31, 0, WINDOW_END_RST, 0, 0);
    add_obs(16'h0002, 4'd15, 11'd700, 40'd0);
    settle();

    // empty window
    write_rule(TRIG_APPEARS, CLASS_VEHICLE, 0, ZONE_ANY, 700, 700, 0, 0);
    add_obs(16'h0002, 4'd0, 11'd700, 40'd0);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_IDX_W'(REG_DWELL + 1 + $urandom_range(0, 7)), $urandom);
        finish_writes();
      end else begin
        pick_random_rule();
      end
      gaps_on   = $urandom_range(0, 2) != 0;
      stalls_on = $urandom_range(0, 2) != 0;
      n = $urandom_range(20, 80);
      queue_random_phase(n);
      total += n;
    end

    settle();
    if (alerts_q.size() != 0) begin
      report_mismatch($sformatf("%0d alerts never arrived", alerts_q.size()));
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
